// File: sv/ecev_pkg.sv
// Package for the easing curve evaluator: fixed-point widths, series coefficients,
// curve codes and the arithmetic helpers shared by the pipeline stages.
// Depends on nothing.
package ecev_pkg;

    // Fixed-point format of progress and of the eased value.
    localparam int F   = 15;
    localparam int XW  = F + 1;
    localparam int YW  = F + 5;
    localparam int D30 = 30 - F;
    localparam int EASED_W = 17;

    localparam logic [XW-1:0] ONE  = XW'(1) << F;
    localparam logic [XW-1:0] HALF = XW'(1) << (F - 1);
    localparam logic [31:0]   Q30  = 32'(1) << 30;

    // Taylor coefficients in Q30 for cos(pi/2 x) and 2^-f.
    localparam logic [31:0] COS_COEF [5] = '{
        32'd1324675879, 32'd272375560, 32'd22401992, 32'd987048, 32'd27060
    };
    localparam logic [31:0] EXP2_COEF [10] = '{
        32'd744261118, 32'd257941247, 32'd59598084, 32'd10327387, 32'd1431680,
        32'd165394, 32'd16377, 32'd1419, 32'd109, 32'd8
    };

    // Overshoot constant of the back curve, and one plus it.
    localparam logic [XW-1:0] BACK_S =
        XW'((64'd1827057613 + (64'd1 << (D30 - 1))) >> D30);
    localparam logic [XW+1:0] BACK_S1 = (XW+2)'(BACK_S) + (XW+2)'(ONE);

    // Bounce offsets 3/4, 15/16 and 63/64.
    localparam logic [XW-1:0] BNC_ADD1 = XW'((3 << F) / 4);
    localparam logic [XW-1:0] BNC_ADD2 = XW'((15 << F) / 16);
    localparam logic [XW-1:0] BNC_ADD3 = XW'((63 << F) / 64);

    // Curve codes.
    localparam logic [5:0] FUNC_LINEAR = 6'd0;
    localparam logic [5:0] FUNC_LAST   = 6'd36;

    localparam logic signed [YW:0] EASED_MIN = (YW+1)'(-65536);
    localparam logic signed [YW:0] EASED_MAX = (YW+1)'(65535);

    typedef enum logic [3:0] {
        FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT, FAM_SINE,
        FAM_EXPO, FAM_CIRC, FAM_BACK, FAM_BOUNCE
    } fam_t;

    typedef enum logic [1:0] {
        FORM_IN, FORM_OUT, FORM_INOUT, FORM_OUTIN
    } form_t;

    // Per-word control that travels beside the data.
    typedef struct packed {
        fam_t            fam;
        form_t           form;
        logic            low;
        logic            bypass;
        logic            unsup;
        logic [XW-1:0]   t;
    } meta_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] res;
    } sqrt_t;

    // Product in Q_F, rounded to nearest.
    function automatic logic [XW+1:0] umulf(input logic [XW+1:0] a, input logic [XW-1:0] b);
        logic [2*XW+1:0] p;
        p = (2*XW+2)'(a) * (2*XW+2)'(b) + (2*XW+2)'(HALF);
        return p[F+XW+1:F];
    endfunction

    // Product in Q30, rounded to nearest.
    function automatic logic [31:0] mul30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + (64'(1) << 29);
        return p[61:30];
    endfunction

    // One digit of the integer square root.
    function automatic sqrt_t sqrt_step(input sqrt_t s, input int i);
        logic [31:0] bitv;
        sqrt_t       r;
        bitv = 32'(1) << (2 * i);
        r = s;
        if (s.rem >= s.res + bitv)
        begin
            r.rem = s.rem - (s.res + bitv);
            r.res = (s.res >> 1) + bitv;
        end
        else
        begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    // Halving with halves rounded away from zero.
    function automatic logic signed [YW:0] shalf(input logic signed [YW:0] v);
        logic [YW:0] m;
        logic [YW:0] r;
        m = v[YW] ? (YW+1)'(-v) : (YW+1)'(v);
        r = (m + (YW+1)'(1)) >> 1;
        return v[YW] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// File: sv/easing_curve_evaluator_top.sv
// Top level of the easing curve evaluator: a fourteen-stage pipeline that
// evaluates all curve families in parallel and picks one at the end.
// Depends on ecev_pkg.
//
//  channel | signals                     | word contents
//  --------+-----------------------------+-------------------------------------
//  input   | s_tvalid s_tready s_tdata   | tdata: progress; tuser: func, two_sides
//  output  | m_tvalid m_tready m_tdata   | tdata: eased; tuser: unsupported
//
// One word is accepted every cycle while the pipeline is not held; the
// depth is set by the exponential curve, whose ten Horner multiplies
// take one stage each.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears the valid bits only.
module easing_curve_evaluator_top
    import ecev_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] progress
    input  logic [6:0]  s_tuser,   // [5:0] func, [6] two_sides
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] eased, [23:17] zero
    output logic [0:0]  m_tuser    // [0] unsupported
);

    localparam int LAST = 13;
    localparam int MW   = XW + 4;
    localparam int KW   = MW - F;
    localparam int BW   = XW + 5;

    logic            en;
    logic            vld_reg [0:LAST];
    logic [XW-1:0]   x_reg [0:10];
    meta_t           meta_reg [0:12];

    logic [5:0]      func_in;
    logic [XW-1:0]   t_sat;
    logic [XW-1:0]   t_half;
    logic [XW-1:0]   t_in;
    logic [XW:0]     t_dbl;
    logic [XW:0]     two_minus;
    logic [5:0]      fm;
    meta_t           meta_in;
    logic [XW-1:0]   x_in;

    // Exponential chain.
    logic [MW-1:0]   ex_m;
    logic [31:0]     ex_f_reg [1:10];
    logic [KW-1:0]   ex_k_reg [1:11];
    logic [31:0]     ex_acc_reg [1:10];
    logic [31:0]     ex_p_reg;
    logic [5:0]      ex_sh;
    logic [32:0]     ex_rnd;
    logic signed [YW-1:0] ex_y_reg;

    // Sine chain.
    logic [31:0]     sn_x30;
    logic [31:0]     sn_u_reg [6:10];
    logic [31:0]     sn_acc_reg [6:10];
    logic [31:0]     sn_p_reg;
    logic [32:0]     sn_r;
    logic signed [YW-1:0] sn_y_reg;

    // Circular chain.
    logic [XW+1:0]   ci_t2;
    sqrt_t           ci_reg [3:11];
    logic signed [YW-1:0] ci_y_reg;

    // Power chain.
    logic [XW+1:0]   po_t2_reg [9:11];
    logic [XW+1:0]   po_t3_reg [10:11];
    logic [XW+1:0]   po_t4_reg [10:11];
    logic [XW+1:0]   po_t5_reg;
    logic [XW+1:0]   po_sel;
    logic signed [YW-1:0] po_y_reg;

    // Back chain.
    logic [XW+1:0]   bk_t2_reg;
    logic [XW+1:0]   bk_a_reg;
    logic signed [XW+2:0] bk_inner;
    logic [XW+2:0]   bk_mag;
    logic [XW+1:0]   bk_r;
    logic signed [YW-1:0] bk_y_reg;

    // Bounce chain.
    logic [XW-1:0]   bo_z;
    logic [BW-1:0]   bo_x11;
    logic signed [BW:0] bo_d;
    logic [BW-1:0]   bo_mag;
    logic            bo_wide;
    logic [XW-1:0]   bo_add;
    logic [BW-1:0]   bo_m_reg;
    logic            bo_wide_reg;
    logic [XW-1:0]   bo_add_reg [10:11];
    logic [2*BW-1:0] bo_sq;
    logic [2*BW-1:0] bo_q;
    logic [XW:0]     bo_q_reg;
    logic signed [YW-1:0] bo_y_reg;

    // Output stage.
    logic signed [YW-1:0] y_sel;
    logic signed [YW:0]   y1;
    logic signed [YW:0]   v;
    logic signed [YW:0]   one_s;
    logic signed [YW:0]   half_s;
    logic signed [YW:0]   v_clamp;
    logic [EASED_W-1:0]   out_eased_reg;
    logic                 out_unsup_reg;

    // The pipeline moves whenever the output register can take a word.
    assign en       = !vld_reg[LAST] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {(24 - EASED_W)'(0), out_eased_reg};
    assign m_tuser  = out_unsup_reg;

    // Saturate, fold and map progress to the argument of the in curve.
    always_comb
    begin
        func_in = s_tuser[5:0];
        if (17'(s_tdata) > 17'(ONE))
            t_sat = ONE;
        else
            t_sat = s_tdata[XW-1:0];
        t_half = (t_sat > HALF) ? ONE - t_sat : t_sat;
        t_in   = s_tuser[6] ? (t_half << 1) : t_sat;
        t_dbl  = {t_in, 1'b0};
        two_minus = {ONE, 1'b0} - t_dbl;
        fm = func_in - 6'd1;
        meta_in.fam    = fam_t'(fm[5:2]);
        meta_in.form   = form_t'(fm[1:0]);
        meta_in.unsup  = func_in > FUNC_LAST;
        meta_in.bypass = (func_in == FUNC_LINEAR) || (func_in > FUNC_LAST);
        meta_in.t      = t_in;
        meta_in.low    = 1'b0;
        x_in           = t_in;
        unique case (form_t'(fm[1:0]))
            FORM_IN:
            begin
                x_in = t_in;
            end
            FORM_OUT:
            begin
                x_in = ONE - t_in;
            end
            FORM_INOUT:
            begin
                meta_in.low = t_in <= HALF;
                x_in = meta_in.low ? t_dbl[XW-1:0] : two_minus[XW-1:0];
            end
            FORM_OUTIN:
            begin
                meta_in.low = t_in < HALF;
                x_in = meta_in.low ? ONE - t_dbl[XW-1:0] : t_dbl[XW-1:0] - ONE;
            end
        endcase
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= LAST; j++)
                vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int j = 1; j <= LAST; j++)
                vld_reg[j] <= vld_reg[j-1];
        end
    end

    // Argument and control delay lines.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_in;
            meta_reg[0] <= meta_in;
            for (int j = 1; j <= 10; j++)
                x_reg[j] <= x_reg[j-1];
            for (int j = 1; j <= 12; j++)
                meta_reg[j] <= meta_reg[j-1];
        end
    end

    // Combinational pieces of the family chains.
    always_comb
    begin
        ex_m   = MW'(10) * (MW'(ONE) - MW'(x_reg[0]));
        ex_sh  = 6'(ex_k_reg[11]) + 6'(D30);
        ex_rnd = (33'(ex_p_reg) + (33'(1) << (ex_sh - 6'd1))) >> ex_sh;

        sn_x30 = 32'(x_reg[5]) << D30;
        sn_r   = (33'(sn_p_reg) + (33'(1) << (D30 - 1))) >> D30;

        ci_t2  = umulf((XW+2)'(x_reg[2]), x_reg[2]);

        bk_inner = $signed({1'b0, bk_a_reg}) - $signed((XW+3)'(BACK_S));
        bk_mag   = bk_inner[XW+2] ? (XW+3)'(-bk_inner) : (XW+3)'(bk_inner);
        bk_r     = umulf(bk_mag[XW+1:0], bk_t2_reg[XW-1:0]);

        bo_z   = ONE - x_reg[9];
        bo_x11 = BW'(bo_z) * BW'(11);
        priority if (bo_x11 < (BW'(4) << F))
        begin
            bo_d = $signed({1'b0, bo_x11});
            bo_wide = 1'b0;
            bo_add = '0;
        end
        else if (bo_x11 < (BW'(8) << F))
        begin
            bo_d = $signed({1'b0, bo_x11}) - $signed((BW+1)'(6) << F);
            bo_wide = 1'b0;
            bo_add = BNC_ADD1;
        end
        else if (bo_x11 < (BW'(10) << F))
        begin
            bo_d = $signed({1'b0, bo_x11}) - $signed((BW+1)'(9) << F);
            bo_wide = 1'b0;
            bo_add = BNC_ADD2;
        end
        else
        begin
            bo_d = $signed((BW+1)'(bo_z) * (BW+1)'(22)) - $signed((BW+1)'(21) << F);
            bo_wide = 1'b1;
            bo_add = BNC_ADD3;
        end
        bo_mag = bo_d[BW] ? BW'(-bo_d) : BW'(bo_d);
        bo_sq  = (2*BW)'(bo_m_reg) * (2*BW)'(bo_m_reg);
        if (bo_wide_reg)
            bo_q = (bo_sq + ((2*BW)'(1) << (F + 5))) >> (F + 6);
        else
            bo_q = (bo_sq + ((2*BW)'(1) << (F + 3))) >> (F + 4);

        unique case (meta_reg[11].fam)
            FAM_QUAD:  po_sel = po_t2_reg[11];
            FAM_CUBIC: po_sel = po_t3_reg[11];
            FAM_QUART: po_sel = po_t4_reg[11];
            default:   po_sel = po_t5_reg;
        endcase
    end

    // Family chains, with no more than one multiply in series per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Exponential: 2^(10(t-1)) through the 2^-f series and a shift.
            ex_f_reg[1]   <= 32'(ex_m[F-1:0]) << D30;
            ex_k_reg[1]   <= ex_m[MW-1:F];
            ex_acc_reg[1] <= EXP2_COEF[9];
            for (int j = 2; j <= 10; j++)
            begin
                ex_f_reg[j]   <= ex_f_reg[j-1];
                ex_k_reg[j]   <= ex_k_reg[j-1];
                ex_acc_reg[j] <= EXP2_COEF[10-j] - mul30(ex_f_reg[j-1], ex_acc_reg[j-1]);
            end
            ex_k_reg[11] <= ex_k_reg[10];
            ex_p_reg     <= Q30 - mul30(ex_f_reg[10], ex_acc_reg[10]);
            ex_y_reg     <= ex_rnd[YW-1:0];

            // Sine: 1 - cos(pi/2 x) from the cosine series in x squared.
            sn_u_reg[6]   <= mul30(sn_x30, sn_x30);
            sn_acc_reg[6] <= COS_COEF[4];
            for (int j = 7; j <= 10; j++)
            begin
                sn_u_reg[j]   <= sn_u_reg[j-1];
                sn_acc_reg[j] <= COS_COEF[10-j] - mul30(sn_u_reg[j-1], sn_acc_reg[j-1]);
            end
            sn_p_reg <= mul30(sn_u_reg[10], sn_acc_reg[10]);
            if (sn_r > 33'(ONE))
                sn_y_reg <= YW'(ONE);
            else
                sn_y_reg <= sn_r[YW-1:0];

            // Circular: one minus the square root of one minus t squared.
            ci_reg[3].rem <= 32'(ONE - ci_t2[XW-1:0]) << F;
            ci_reg[3].res <= '0;
            for (int j = 4; j <= 11; j++)
                ci_reg[j] <= sqrt_step(sqrt_step(ci_reg[j-1], 2 * (11 - j) + 1), 2 * (11 - j));
            ci_y_reg <= YW'(ONE) - ci_reg[11].res[YW-1:0];

            // Powers two to five.
            po_t2_reg[9]  <= umulf((XW+2)'(x_reg[8]), x_reg[8]);
            po_t2_reg[10] <= po_t2_reg[9];
            po_t3_reg[10] <= umulf(po_t2_reg[9], x_reg[9]);
            po_t4_reg[10] <= umulf(po_t2_reg[9], po_t2_reg[9][XW-1:0]);
            po_t2_reg[11] <= po_t2_reg[10];
            po_t3_reg[11] <= po_t3_reg[10];
            po_t4_reg[11] <= po_t4_reg[10];
            po_t5_reg     <= umulf(po_t4_reg[10], x_reg[10]);
            po_y_reg      <= YW'(po_sel);

            // Back: t squared times ((s+1) t - s).
            bk_t2_reg <= umulf((XW+2)'(x_reg[10]), x_reg[10]);
            bk_a_reg  <= umulf(BACK_S1, x_reg[10]);
            bk_y_reg  <= bk_inner[XW+2] ? -$signed(YW'(bk_r)) : $signed(YW'(bk_r));

            // Bounce: piecewise parabola on 11 (1-t), mirrored.
            bo_m_reg       <= bo_mag;
            bo_wide_reg    <= bo_wide;
            bo_add_reg[10] <= bo_add;
            bo_add_reg[11] <= bo_add_reg[10];
            bo_q_reg       <= bo_q[XW:0];
            bo_y_reg       <= $signed(YW'(ONE)) - $signed(YW'(bo_q_reg) + YW'(bo_add_reg[11]));
        end
    end

    // Pick the family, apply the form and saturate.
    always_comb
    begin
        unique case (meta_reg[12].fam)
            FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT: y_sel = po_y_reg;
            FAM_SINE:   y_sel = sn_y_reg;
            FAM_EXPO:   y_sel = ex_y_reg;
            FAM_CIRC:   y_sel = ci_y_reg;
            FAM_BACK:   y_sel = bk_y_reg;
            FAM_BOUNCE: y_sel = bo_y_reg;
            default:    y_sel = '0;
        endcase
        y1     = {y_sel[YW-1], y_sel};
        one_s  = $signed((YW+1)'(ONE));
        half_s = $signed((YW+1)'(HALF));
        unique case (meta_reg[12].form)
            FORM_IN:    v = y1;
            FORM_OUT:   v = one_s - y1;
            FORM_INOUT: v = meta_reg[12].low ? shalf(y1) : one_s - shalf(y1);
            FORM_OUTIN: v = meta_reg[12].low ? shalf(one_s - y1) : half_s + shalf(y1);
        endcase
        if (meta_reg[12].bypass)
            v = $signed((YW+1)'(meta_reg[12].t));
        if (v < EASED_MIN)
            v_clamp = EASED_MIN;
        else if (v > EASED_MAX)
            v_clamp = EASED_MAX;
        else
            v_clamp = v;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_eased_reg <= v_clamp[EASED_W-1:0];
            out_unsup_reg <= meta_reg[12].unsup;
        end
    end

endmodule
